>>> rtl/core/signed_int_to_decimal_ascii_top_macros.svh
// Assertion macros shared by the checker of signed_int_to_decimal_ascii_top.
// Depends on signals named clk and rst in the scope of use.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define I2DEC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2dec check failed");

// next-cycle implication, off during reset
`define I2DEC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2dec check failed");

`endif

>>> rtl/core/i2dec_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII block.
// No dependencies.
package i2dec_pkg;

  localparam logic [5:0] CHAR_MINUS = 6'd45;
  localparam logic [5:0] CHAR_ZERO  = 6'd48;
  localparam int unsigned NUM_POS   = 10;

  // powers of ten, indexed by digit position
  localparam logic [31:0] POW10 [NUM_POS] = '{
    32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
    32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
  };

  // classified request between front and back
  typedef struct packed {
    logic        neg;
    logic [31:0] mag;
    logic [3:0]  top;   // position of the leading digit
  } entry_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> rtl/core/i2dec_front.sv
// Front end: takes a request, forms sign and magnitude, finds the leading digit.
// Depends on i2dec_pkg.
module i2dec_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [31:0]           value,
  output logic                  busy,
  input  i2dec_pkg::q_status_t  q_stat,
  output logic                  push,
  output i2dec_pkg::entry_t     push_data
);

  logic        fv;
  logic        neg;
  logic [31:0] mag;
  logic [3:0]  top;
  logic        accept;

  assign busy   = fv && q_stat.full;
  assign accept = start && !busy;
  assign push   = fv && !q_stat.full;

  always_comb begin
    top = 4'd0;
    for (int p = 1; p < int'(i2dec_pkg::NUM_POS); p++) begin
      if (mag >= i2dec_pkg::POW10[p]) top = 4'(p);
    end
  end

  assign push_data = '{neg: neg, mag: mag, top: top};

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (accept) begin
      fv <= 1'b1;
    end else if (push) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= value[31];
      mag <= value[31] ? (32'd0 - value) : value;
    end
  end

endmodule

>>> rtl/core/i2dec_queue.sv
// Two-entry queue of classified requests between front and back.
// Depends on i2dec_pkg.
module i2dec_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  i2dec_pkg::entry_t     push_data,
  input  logic                  pop,
  output i2dec_pkg::entry_t     head,
  output i2dec_pkg::q_status_t  q_stat
);

  i2dec_pkg::entry_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_stat.full  = (count == 2'd2);
  assign q_stat.empty = (count == 2'd0);
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

>>> rtl/core/i2dec_back.sv
// Back end: emits a minus sign for a negative value and then one decimal digit per cycle, leading digit first.
// Depends on i2dec_pkg.
module i2dec_back (
  input  logic                  clk,
  input  logic                  rst,
  input  i2dec_pkg::q_status_t  q_stat,
  input  i2dec_pkg::entry_t     head,
  output logic                  pop,
  output logic                  strobe,
  output logic [5:0]            char_code,
  output logic                  last_char
);

  logic        active;
  logic        minus_pend;
  logic [31:0] mag;
  logic [3:0]  pos;

  logic [33:0] thr [9];
  logic [33:0] sub;
  logic [3:0]  dig;
  logic        finishing;

  // k * 10^pos for k = 1..9, folded from constants
  always_comb begin
    for (int k = 1; k <= 9; k++) begin
      thr[k-1] = 34'd0;
      for (int p = 0; p < int'(i2dec_pkg::NUM_POS); p++) begin
        if (pos == 4'(p)) thr[k-1] = 34'(k) * 34'(i2dec_pkg::POW10[p]);
      end
    end
  end

  // remaining magnitude is below 10^(pos+1), so the thresholds are monotonic
  always_comb begin
    dig = 4'd0;
    sub = 34'd0;
    for (int k = 1; k <= 9; k++) begin
      if ({2'b00, mag} >= thr[k-1]) begin
        dig = 4'(k);
        sub = thr[k-1];
      end
    end
  end

  assign finishing = active && !minus_pend && (pos == 4'd0);
  assign pop       = !q_stat.empty && (!active || finishing);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (pop) begin
        active <= 1'b1;
      end else if (finishing) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      if (minus_pend) begin
        char_code <= i2dec_pkg::CHAR_MINUS;
        last_char <= 1'b0;
      end else begin
        char_code <= i2dec_pkg::CHAR_ZERO + {2'b00, dig};
        last_char <= (pos == 4'd0);
      end
    end
    // a pop only happens when idle or on the last digit, so it replaces the digit step
    if (pop) begin
      minus_pend <= head.neg;
      mag        <= head.mag;
      pos        <= head.top;
    end else if (active) begin
      if (minus_pend) begin
        minus_pend <= 1'b0;
      end else begin
        mag <= mag - sub[31:0];
        pos <= pos - 4'd1;
      end
    end
  end

endmodule

>>> rtl/core/signed_int_to_decimal_ascii_top.sv
// Top level: signed 32-bit integer to decimal ASCII characters.
// Depends on i2dec_pkg, i2dec_front, i2dec_queue, i2dec_back.
//
//  channel   handshake            payload
//  request   start / busy         value[31:0] (signed)
//  result    strobe (one cycle)   char_code[5:0], last_char
//
// A number leaves as 1 to 11 characters, one per cycle; the back end's digit
// loop sets the rate and emits a minus sign for a negative value, then its digits.
// A request passes the front register, the queue and the back end's digit state.
// Two queued requests plus one in the front can wait; busy rises when all are full.
// rst is synchronous and clears all valid and count state.
// The receiver cannot stall; strobe marks each character for exactly one cycle.
module signed_int_to_decimal_ascii_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] value,
  output logic               busy,
  output logic               strobe,
  output logic [5:0]         char_code,
  output logic               last_char
);

  i2dec_pkg::q_status_t q_stat;
  i2dec_pkg::entry_t    push_data;
  i2dec_pkg::entry_t    head;
  logic                 push;
  logic                 pop;

  i2dec_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .value     (value),
    .busy      (busy),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  i2dec_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  i2dec_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .strobe    (strobe),
    .char_code (char_code),
    .last_char (last_char)
  );

endmodule

>>> rtl/core/i2dec_checker.sv
// Port-level checks for signed_int_to_decimal_ascii_top, attached by bind.
// Depends on signed_int_to_decimal_ascii_top_macros.svh and i2dec_pkg.
`include "signed_int_to_decimal_ascii_top_macros.svh"

module i2dec_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic signed [31:0] value,
  input logic               busy,
  input logic               strobe,
  input logic [5:0]         char_code,
  input logic               last_char
);

  logic is_minus;
  logic is_zero;
  logic is_digit;
  logic prev_strobe;
  logic prev_last;
  logic prev_minus;
  logic lead_pos;

  assign is_minus = (char_code == i2dec_pkg::CHAR_MINUS);
  assign is_zero  = (char_code == i2dec_pkg::CHAR_ZERO);
  assign is_digit = (char_code >= i2dec_pkg::CHAR_ZERO) &&
                    (char_code <= i2dec_pkg::CHAR_ZERO + 6'd9);
  // slot of a leading digit: after a gap, after the end of a number, or after '-'
  assign lead_pos = !prev_strobe || prev_last || prev_minus;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_strobe <= 1'b0;
      prev_last   <= 1'b0;
      prev_minus  <= 1'b0;
    end else begin
      prev_strobe <= strobe;
      prev_last   <= last_char;
      prev_minus  <= strobe && is_minus;
    end
  end

  // only '-' or a digit ever leaves
  `I2DEC_ASSERT_NOW(a_legal_char, strobe, is_minus || is_digit)

  // the sign never ends a number
  `I2DEC_ASSERT_NOW(a_minus_not_last, strobe && is_minus, !last_char)

  // characters of one number come in consecutive cycles
  `I2DEC_ASSERT_NEXT(a_no_gap, strobe && !last_char, strobe && !is_minus)

  // a leading zero is only the number zero itself
  `I2DEC_ASSERT_NOW(a_no_lead_zero, strobe && is_zero && lead_pos, last_char && !prev_minus)

endmodule

bind signed_int_to_decimal_ascii_top i2dec_checker u_i2dec_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .value     (value),
  .busy      (busy),
  .strobe    (strobe),
  .char_code (char_code),
  .last_char (last_char)
);
